// File: sv/deq_pkg.sv
// Package for the double-ended queue: sizes, opcodes, controller/datapath structs
// and the ring index helpers.
// No dependencies.
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // fixed widths of the channel fields
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int OCC_W = 5;

    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_opcode;

    // controller -> datapath
    typedef struct packed {
        logic    exec;      // item transferred this cycle
        t_opcode op;
        logic    load_pop;  // RAM read data is valid, capture it
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_status;

    // (base + off) mod DEPTH, both operands already below DEPTH
    function automatic t_addr ring_add(input t_addr base, input t_addr off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic t_addr ring_inc(input t_addr idx);
        return (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic t_addr ring_dec(input t_addr idx);
        return (idx == '0) ? ADDR_W'(DEPTH - 1) : idx - 1'b1;
    endfunction

endpackage

// File: sv/deq_in_if.sv
// Request channel of the double-ended queue: valid/ready plus opcode and value.
// Depends on deq_pkg.
interface deq_in_if;
    logic                       valid;
    logic                       ready;
    logic [deq_pkg::OP_W-1:0]   opcode;
    logic [deq_pkg::VAL_W-1:0]  push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

// File: sv/deq_out_if.sv
// Result channel of the double-ended queue: valid/ready plus status, value, occupancy.
// Depends on deq_pkg.
interface deq_out_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [deq_pkg::VAL_W-1:0]  pop_value;
    logic [deq_pkg::OCC_W-1:0]  occupancy;

    modport source (output valid, output ok, output pop_value, output occupancy,
                    input ready);
    modport sink   (input valid, input ok, input pop_value, input occupancy,
                    output ready);
endinterface

// File: sv/double_ended_queue.sv
// Top level of the bounded double-ended queue: request and result channels,
// controller and datapath. Depends on deq_pkg, deq_in_if, deq_out_if,
// deq_ctrl and deq_dp.
//
// Usage:
//   i_req carries one operation per transfer: opcode (push front, push back,
//   pop front, pop back) and push_value. o_rsp returns exactly one result per
//   request: ok, pop_value (zero unless a pop succeeded) and the occupancy
//   after the operation. A push into a full queue or a pop from an empty one
//   gives ok = 0 and leaves the queue untouched.
//   Pushes and failed pops show their result the cycle after the transfer;
//   a successful pop passes through the registered read of the slot RAM
//   and then the result register.
//   Throughput: one push or failed pop per cycle while results are taken;
//   a successful pop holds off new requests until its RAM read is captured.
//   Reset (synchronous, i_rst_n low) empties the queue and drops any
//   pending result; slot contents are not cleared.
//   A stalled result holds in the output register; a new request is still
//   taken in the cycle the waiting result is transferred.
module double_ended_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_in_if.sink     i_req,
    deq_out_if.source  o_rsp
);

    deq_pkg::t_cmd    cmd;
    deq_pkg::t_status status;
    logic             in_ready;
    logic             out_valid;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_opcode    (i_req.opcode),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    deq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_value (i_req.push_value),
        .o_status     (status),
        .o_ok         (o_rsp.ok),
        .o_pop_value  (o_rsp.pop_value),
        .o_occupancy  (o_rsp.occupancy)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule

// File: sv/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/deq_dp.sv
// Datapath of the double-ended queue: ring pointers, slot RAM and result register.
// Depends on deq_pkg and deq_ram.
module deq_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  deq_pkg::t_cmd             i_cmd,
    input  logic [deq_pkg::VAL_W-1:0] i_push_value,
    output deq_pkg::t_status          o_status,
    output logic                      o_ok,
    output logic [deq_pkg::VAL_W-1:0] o_pop_value,
    output logic [deq_pkg::OCC_W-1:0] o_occupancy
);

    deq_pkg::t_addr  r_front;
    deq_pkg::t_count r_count;
    logic            r_ok;
    logic [deq_pkg::VAL_W-1:0] r_pop_value;
    logic [deq_pkg::OCC_W-1:0] r_occupancy;

    deq_pkg::t_addr  n_front;
    deq_pkg::t_count n_count;
    logic            is_push;
    logic            op_ok;
    logic            we;
    deq_pkg::t_addr  waddr;
    deq_pkg::t_addr  raddr;
    deq_pkg::t_addr  back_addr;
    deq_pkg::t_addr  last_addr;
    deq_pkg::t_data  rdata;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == deq_pkg::CNT_W'(deq_pkg::DEPTH));

    assign is_push = (i_cmd.op == deq_pkg::OP_PUSH_FRONT) ||
                     (i_cmd.op == deq_pkg::OP_PUSH_BACK);
    assign op_ok   = is_push ? !o_status.full : !o_status.empty;

    // slot just past the back, and the back slot itself
    assign back_addr = deq_pkg::ring_add(r_front, r_count[deq_pkg::ADDR_W-1:0]);
    assign last_addr = deq_pkg::ring_add(r_front,
                           deq_pkg::ADDR_W'(r_count - 1'b1));

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        we      = 1'b0;
        waddr   = back_addr;
        raddr   = r_front;
        if (i_cmd.exec && op_ok) begin
            case (i_cmd.op)
                deq_pkg::OP_PUSH_FRONT: begin
                    n_front = deq_pkg::ring_dec(r_front);
                    waddr   = n_front;
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                end
                deq_pkg::OP_PUSH_BACK: begin
                    waddr   = back_addr;
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                end
                deq_pkg::OP_POP_FRONT: begin
                    raddr   = r_front;
                    n_front = deq_pkg::ring_inc(r_front);
                    n_count = r_count - 1'b1;
                end
                default: begin
                    raddr   = last_addr;
                    n_count = r_count - 1'b1;
                end
            endcase
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::DATA_WIDTH),
        .DEPTH (deq_pkg::DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (deq_pkg::DATA_WIDTH'(i_push_value)),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // result payload; pop data is captured from the registered RAM read on load_pop
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok        <= op_ok;
            r_occupancy <= deq_pkg::OCC_W'(n_count);
            r_pop_value <= '0;
        end else if (i_cmd.load_pop) begin
            r_pop_value <= deq_pkg::VAL_W'(rdata);
        end
    end

    assign o_ok        = r_ok;
    assign o_pop_value = r_pop_value;
    assign o_occupancy = r_occupancy;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
        else $error("stored count above depth");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && !op_ok |=> $stable(r_count) && $stable(r_front))
        else $error("refused operation changed the pointers");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && op_ok && is_push |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted push did not grow the queue");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && op_ok && !is_push |=> r_count == $past(r_count) - 1'b1)
        else $error("accepted pop did not shrink the queue");

endmodule

// File: sv/deq_ctrl.sv
// Controller of the double-ended queue: handshake, sequencing of RAM reads,
// result valid flag.
// Depends on deq_pkg.
module deq_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [deq_pkg::OP_W-1:0] i_opcode,
    input  logic                     i_out_ready,
    input  deq_pkg::t_status         i_status,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output deq_pkg::t_cmd            o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state           r_state;
    logic             r_out_valid;
    deq_pkg::t_opcode op;
    logic             accept;
    logic             pop_hit;

    assign op         = deq_pkg::t_opcode'(i_opcode);
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign pop_hit    = accept && !i_status.empty &&
                        ((op == deq_pkg::OP_POP_FRONT) || (op == deq_pkg::OP_POP_BACK));

    assign o_cmd.exec     = accept;
    assign o_cmd.op       = op;
    assign o_cmd.load_pop = (r_state == S_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (pop_hit) begin
                        r_state     <= S_READ;
                        r_out_valid <= 1'b0;
                    end else if (accept) begin
                        r_out_valid <= 1'b1;
                    end else if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    // output register is free here: the transfer waited for it
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_hit |=> r_state == S_READ && !r_out_valid)
        else $error("successful pop did not wait for the RAM read");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_state == S_IDLE && r_out_valid)
        else $error("read cycle did not present its result");

    a_no_take_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !o_in_ready)
        else $error("request taken during a RAM read");

endmodule
